[design/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

[design/slfd_pkg.sv]
// Package for the sync/type/length frame deframer.
// Holds register indexes, widths and reset values; no dependencies.
`default_nettype none

package slfd_pkg;

	localparam int HEADER_BYTES = 5;
	localparam int FILL_W       = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_SYNC_FIRST  = 2'd0;
	localparam cfg_idx_t CFG_SYNC_SECOND = 2'd1;
	localparam cfg_idx_t CFG_MAX_PAYLOAD = 2'd2;

	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

endpackage

`default_nettype wire

[design/slfd_if.sv]
// Stream channel interfaces for the deframer: raw bytes in, frame beats out.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface slfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface slfd_frame_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_type;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic        frame_end;
	logic [15:0] payload_length;
	logic [31:0] resync_total;

	modport source (output valid, output frame_type, output payload_byte,
		output payload_valid, output frame_end, output payload_length,
		output resync_total, input ready);
	modport sink   (input valid, input frame_type, input payload_byte,
		input payload_valid, input frame_end, input payload_length,
		input resync_total, output ready);
endinterface

`default_nettype wire

[design/sync_length_frame_deframer_top.sv]
// Channel   Dir  Beat
// rx        in   one raw link byte (data_byte)
// frame     out  type, payload byte, valid/end marks, length, resync total
// cfg_*     in   register write: sync_first, sync_second, max_payload
//
// A payload byte is accepted, then loaded into the output register in the load state.
// A header byte is accepted, then checked in the scan loop, one window check per cycle
// (each slip drops one byte and checks again; up to 5 slips, then one last check).
// An empty frame then passes to the load state to load its result.
// arst_n clears control state and loads register reset values.
// The output register frees rx while a beat waits on frame.ready; a new
// result stalls in the load state until that register is free.
// Depends on slfd_pkg, slfd_if.sv and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sync_length_frame_deframer_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	slfd_byte_if.sink                         rx,
	slfd_frame_if.source                      frame,
	input  wire logic                         cfg_we,
	input  wire slfd_pkg::cfg_idx_t           cfg_index,
	input  wire logic [slfd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [slfd_pkg::FILL_W-1:0] FILL_FULL =
		slfd_pkg::FILL_W'(slfd_pkg::HEADER_BYTES);

	logic [1:0]  state_q;
	logic [7:0]  sync_first_q;
	logic [7:0]  sync_second_q;
	logic [15:0] max_payload_q;

	logic [7:0]                   win_q [slfd_pkg::HEADER_BYTES];
	logic [slfd_pkg::FILL_W-1:0]  fill_q;
	logic                         in_payload_q;
	logic [15:0]                  bytes_left_q;
	logic [7:0]                   cur_type_q;
	logic [15:0]                  cur_len_q;
	logic [31:0]                  resync_q;

	logic [7:0] pend_byte_q;
	logic       pend_valid_q;
	logic       pend_end_q;

	logic        out_valid_q;
	logic [7:0]  out_type_q;
	logic [7:0]  out_byte_q;
	logic        out_pv_q;
	logic        out_end_q;
	logic [15:0] out_len_q;
	logic [31:0] out_resync_q;

	logic        rx_fire;
	logic        out_free;
	logic        load_out;
	logic        bad_first;
	logic        bad_second;
	logic        win_full;
	logic [15:0] hdr_len;
	logic        too_long;
	logic        drop;
	logic        hdr_ok;
	logic [15:0] left_next;

	assign rx.ready = (state_q == ST_IDLE);
	assign rx_fire  = rx.valid && rx.ready;
	assign out_free = !out_valid_q || frame.ready;
	assign load_out = (state_q == ST_EMIT) && out_free;

	// One window check per scan cycle, in priority order.
	assign bad_first  = (fill_q >= 3'd1) && (win_q[0] != sync_first_q);
	assign bad_second = (fill_q >= 3'd2) && (win_q[1] != sync_second_q);
	assign win_full   = (fill_q == FILL_FULL);
	assign hdr_len    = {win_q[4], win_q[3]};
	assign too_long   = hdr_len > max_payload_q;
	assign drop       = bad_first || bad_second || (win_full && too_long);
	assign hdr_ok     = !bad_first && !bad_second && win_full && !too_long;
	assign left_next  = bytes_left_q - 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= slfd_pkg::SYNC_FIRST_RST;
			sync_second_q <= slfd_pkg::SYNC_SECOND_RST;
			max_payload_q <= slfd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slfd_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data[7:0];
				slfd_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data[7:0];
				slfd_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			in_payload_q <= 1'b0;
			bytes_left_q <= '0;
			cur_type_q   <= '0;
			cur_len_q    <= '0;
			resync_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rx_fire) begin
						if (in_payload_q) begin
							bytes_left_q <= left_next;
							if (left_next == 16'd0)
								in_payload_q <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							if (fill_q < FILL_FULL)
								fill_q <= fill_q + 3'd1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (drop) begin
						// slip one byte and check the window again
						if (fill_q != '0)
							fill_q <= fill_q - 3'd1;
						resync_q <= resync_q + 32'd1;
					end else if (hdr_ok) begin
						cur_type_q <= win_q[2];
						cur_len_q  <= hdr_len;
						fill_q     <= '0;
						if (hdr_len == 16'd0) begin
							state_q <= ST_EMIT;
						end else begin
							in_payload_q <= 1'b1;
							bytes_left_q <= hdr_len;
							state_q      <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Window storage and pending result: data only, no reset.
	always_ff @(posedge clk) begin
		if (rx_fire) begin
			if (in_payload_q) begin
				pend_byte_q  <= rx.data_byte;
				pend_valid_q <= 1'b1;
				pend_end_q   <= (left_next == 16'd0);
			end else if (fill_q < FILL_FULL) begin
				win_q[fill_q] <= rx.data_byte;
			end
		end else if (state_q == ST_SCAN) begin
			if (drop) begin
				for (int k = 0; k < slfd_pkg::HEADER_BYTES - 1; k++)
					win_q[k] <= win_q[k+1];
			end else if (hdr_ok) begin
				pend_byte_q  <= 8'd0;
				pend_valid_q <= 1'b0;
				pend_end_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (frame.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_type_q   <= cur_type_q;
			out_byte_q   <= pend_byte_q;
			out_pv_q     <= pend_valid_q;
			out_end_q    <= pend_end_q;
			out_len_q    <= cur_len_q;
			out_resync_q <= resync_q;
		end
	end

	assign frame.valid          = out_valid_q;
	assign frame.frame_type     = out_type_q;
	assign frame.payload_byte   = out_byte_q;
	assign frame.payload_valid  = out_pv_q;
	assign frame.frame_end      = out_end_q;
	assign frame.payload_length = out_len_q;
	assign frame.resync_total   = out_resync_q;

	`ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q > FILL_FULL)
	`ASSERT_HOLDS(a_payload_empty_win, clk, arst_n, in_payload_q |-> (fill_q == '0))
	`ASSERT_HOLDS(a_payload_left, clk, arst_n, in_payload_q |-> (bytes_left_q != 16'd0))
	`ASSERT_HOLDS(a_slip_counts, clk, arst_n,
		(state_q == ST_SCAN && drop) |=> (resync_q == $past(resync_q) + 32'd1))

endmodule

`default_nettype wire
